@@ rtl/chr_pkg.sv @@
// shared constants, codes and types for the chunk header check and reassembly block
`timescale 1ns / 1ps

package chr_pkg;

    localparam int CHR_STORE_BYTES  = 1024;
    localparam int CHR_HEADER_BYTES = 4;

    localparam int LEN_W   = 11;
    localparam int ID_W    = 16;
    localparam int CHUNK_W = 8;
    localparam int BYTE_W  = 8;
    localparam int RIDX_W  = 10;
    localparam int STAT_W  = 3;
    localparam int HPOS_W  = 3;
    localparam int HDR_W   = (CHR_HEADER_BYTES - 1) * BYTE_W;

    localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(1024);

    typedef enum logic [STAT_W-1:0] {
        STAT_ACCEPTED,
        STAT_COMPLETE,
        STAT_BAD_HEADER,
        STAT_SEQ_RESET,
        STAT_OVF_RESET,
        STAT_READ
    } status_t;

    typedef enum logic [1:0] {
        VERDICT_GOOD,
        VERDICT_BAD,
        VERDICT_SEQ,
        VERDICT_OVF
    } verdict_t;

    typedef struct packed {
        status_t              status;
        logic [ID_W-1:0]      msg_id;
        logic [LEN_W-1:0]     message_length;
        logic [CHUNK_W-1:0]   chunks_taken;
        logic                 rd_sel;
    } result_t;

endpackage

@@ rtl/chr_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps

module chr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/chr_assembler.sv @@
// header check, sequence tracking and buffer addressing for one item per cycle while item_go is high
`timescale 1ns / 1ps

module chr_assembler
    import chr_pkg::*;
#(
    parameter int STORE_BYTES = CHR_STORE_BYTES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [LEN_W-1:0]                 cfg_wr_data,
    input  logic                             item_go,
    input  logic                             item_kind,
    input  logic [BYTE_W-1:0]                item_byte,
    input  logic                             item_last,
    input  logic [RIDX_W-1:0]                item_ridx,
    output result_t                          res,
    output logic                             mem_en,
    output logic                             mem_we,
    output logic [$clog2(STORE_BYTES)-1:0]   mem_addr,
    output logic [BYTE_W-1:0]                mem_wdata
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam logic [HPOS_W-1:0] HDR_END = HPOS_W'(CHR_HEADER_BYTES);

    logic [LEN_W-1:0]   limit_reg;
    logic [LEN_W-1:0]   len_reg,     len_next;
    logic [ID_W-1:0]    id_reg,      id_next;
    logic [CHUNK_W-1:0] cnt_reg,     cnt_next;
    logic [CHUNK_W-1:0] nxt_reg,     nxt_next;
    logic [HPOS_W-1:0]  hpos_reg,    hpos_next;
    logic [HDR_W-1:0]   hdr_reg,     hdr_next;
    verdict_t           verdict_reg, verdict_next;

    logic [LEN_W-1:0]   eff_lim;
    logic [ID_W-1:0]    hdr_id;
    logic [CHUNK_W-1:0] hdr_idx;
    logic [CHUNK_W-1:0] hdr_cnt;
    status_t            status;

    assign eff_lim = (32'(limit_reg) < 32'(STORE_BYTES)) ? limit_reg : LEN_W'(STORE_BYTES);
    assign hdr_id  = hdr_reg[HDR_W-1:BYTE_W];
    assign hdr_idx = hdr_reg[BYTE_W-1:0];
    assign hdr_cnt = item_byte;

    always_comb begin
        len_next     = len_reg;
        id_next      = id_reg;
        cnt_next     = cnt_reg;
        nxt_next     = nxt_reg;
        hpos_next    = hpos_reg;
        hdr_next     = hdr_reg;
        verdict_next = verdict_reg;
        status       = STAT_ACCEPTED;
        mem_en       = 1'b0;
        mem_we       = 1'b0;
        mem_addr     = AW'(32'(len_reg));
        mem_wdata    = item_byte;

        if (item_go && item_kind) begin
            // buffer read, state untouched
            status   = STAT_READ;
            mem_en   = 1'b1;
            mem_addr = AW'(32'(item_ridx));
        end else if (item_go) begin
            if (hpos_reg < HDR_END) begin
                hpos_next = hpos_reg + 1'b1;
                hdr_next  = {hdr_reg[HDR_W-BYTE_W-1:0], item_byte};
                if (hpos_reg == HDR_END - 1'b1) begin
                    if (hdr_cnt == '0 || hdr_idx >= hdr_cnt) begin
                        verdict_next = VERDICT_BAD;
                    end else if (hdr_idx == '0) begin
                        // first chunk restarts the message
                        len_next     = '0;
                        id_next      = hdr_id;
                        cnt_next     = hdr_cnt;
                        nxt_next     = '0;
                        verdict_next = VERDICT_GOOD;
                    end else if (cnt_reg == '0 || id_reg != hdr_id || cnt_reg != hdr_cnt ||
                                 nxt_reg != hdr_idx) begin
                        len_next     = '0;
                        id_next      = '0;
                        cnt_next     = '0;
                        nxt_next     = '0;
                        verdict_next = VERDICT_SEQ;
                    end else if (len_reg > eff_lim) begin
                        len_next     = '0;
                        id_next      = '0;
                        cnt_next     = '0;
                        nxt_next     = '0;
                        verdict_next = VERDICT_OVF;
                    end else begin
                        verdict_next = VERDICT_GOOD;
                    end
                end
            end else if (verdict_reg == VERDICT_GOOD) begin
                if (len_reg >= eff_lim) begin
                    len_next     = '0;
                    id_next      = '0;
                    cnt_next     = '0;
                    nxt_next     = '0;
                    verdict_next = VERDICT_OVF;
                end else begin
                    mem_en   = (32'(len_reg) < 32'(STORE_BYTES));
                    mem_we   = (32'(len_reg) < 32'(STORE_BYTES));
                    len_next = len_reg + 1'b1;
                end
            end

            if (item_last) begin
                if (hpos_next < HDR_END || verdict_next == VERDICT_BAD) begin
                    status = STAT_BAD_HEADER;
                end else if (verdict_next == VERDICT_SEQ) begin
                    status = STAT_SEQ_RESET;
                end else if (verdict_next == VERDICT_OVF) begin
                    status = STAT_OVF_RESET;
                end else begin
                    nxt_next = nxt_next + 1'b1;
                    status   = (nxt_next == cnt_next) ? STAT_COMPLETE : STAT_ACCEPTED;
                end
                hpos_next    = '0;
                hdr_next     = '0;
                verdict_next = VERDICT_GOOD;
            end
        end
    end

    always_comb begin
        res.status         = status;
        res.msg_id         = id_next;
        res.message_length = len_next;
        res.chunks_taken   = nxt_next;
        res.rd_sel         = item_kind && (32'(item_ridx) < 32'(len_reg)) &&
                             (32'(item_ridx) < 32'(STORE_BYTES));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= LIMIT_RESET;
            len_reg     <= '0;
            id_reg      <= '0;
            cnt_reg     <= '0;
            nxt_reg     <= '0;
            hpos_reg    <= '0;
            hdr_reg     <= '0;
            verdict_reg <= VERDICT_GOOD;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            len_reg     <= len_next;
            id_reg      <= id_next;
            cnt_reg     <= cnt_next;
            nxt_reg     <= nxt_next;
            hpos_reg    <= hpos_next;
            hdr_reg     <= hdr_next;
            verdict_reg <= verdict_next;
        end
    end

`ifndef SYNTHESIS
    a_len_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(len_reg) <= 32'(STORE_BYTES))
        else $error("assembled length beyond store");

    a_hpos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hpos_reg <= HDR_END)
        else $error("header position beyond header");

    a_closed_is_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == '0 |-> (nxt_reg == '0 && id_reg == '0 && len_reg == '0))
        else $error("closed message holds state");

    a_verdict_after_header: assert property (@(posedge aclk) disable iff (!aresetn)
        verdict_reg != VERDICT_GOOD |-> hpos_reg == HDR_END)
        else $error("verdict set before header complete");

    a_write_only_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (item_go && !item_kind && hpos_reg == HDR_END))
        else $error("buffer write outside payload");
`endif

endmodule

@@ rtl/chunk_header_check_and_reassembly.sv @@
// top level: input register, assembler, message buffer and result register
`timescale 1ns / 1ps

// Chunk header check and in-order reassembly.
// Input channel s_*: one item per handshake, either a chunk byte (s_kind 0,
// header first, s_end_of_chunk on the last byte) or a buffer read (s_kind 1
// at s_read_index). Result channel m_*: one item for each read and one for
// each end of chunk; other chunk bytes give no result.
// cfg_wr_en / cfg_wr_data set the message length limit (reset value 1024),
// which the user must write only while the block is idle; the block does not enforce it.
// An accepted item waits in the input register until it can step; its result
// is then loaded into the result register, which drives m_valid.
// One item per cycle while no stalled result blocks the step; the state update
// and the single buffer access (one write or one registered read) happen
// together in the same cycle.
// When the receiver stalls, the result register holds its item and the input
// register takes one more item; items without a result keep flowing.
// Reset (aresetn low, synchronous) closes the message, clears the header
// state, empties both registers and restores the limit. The buffer contents
// are not cleared; bytes at or past the message length read as 0.
module chunk_header_check_and_reassembly
    import chr_pkg::*;
#(
    parameter int STORE_BYTES = CHR_STORE_BYTES
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic [LEN_W-1:0]    cfg_wr_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [BYTE_W-1:0]   s_data_byte,
    input  logic                s_end_of_chunk,
    input  logic [RIDX_W-1:0]   s_read_index,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [STAT_W-1:0]   m_status,
    output logic [ID_W-1:0]     m_msg_id,
    output logic [LEN_W-1:0]    m_message_length,
    output logic [CHUNK_W-1:0]  m_chunks_taken,
    output logic [BYTE_W-1:0]   m_read_data
);

    localparam int AW = $clog2(STORE_BYTES);

    logic                in_vld_reg;
    logic                in_kind_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                in_last_reg;
    logic [RIDX_W-1:0]   in_ridx_reg;

    logic                out_vld_reg;
    result_t             res_reg;

    logic                has_result;
    logic                out_free;
    logic                step_go;
    result_t             res;
    logic                mem_en;
    logic                mem_we;
    logic [AW-1:0]       mem_addr;
    logic [BYTE_W-1:0]   mem_wdata;
    logic [BYTE_W-1:0]   mem_rdata;

    assign has_result = in_kind_reg || in_last_reg;
    assign out_free   = !out_vld_reg || m_ready;
    assign step_go    = in_vld_reg && (!has_result || out_free);
    assign s_ready    = !in_vld_reg || step_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_end_of_chunk;
            in_ridx_reg <= s_read_index;
        end
    end

    chr_assembler #(
        .STORE_BYTES (STORE_BYTES)
    ) u_assembler (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_go     (step_go),
        .item_kind   (in_kind_reg),
        .item_byte   (in_byte_reg),
        .item_last   (in_last_reg),
        .item_ridx   (in_ridx_reg),
        .res         (res),
        .mem_en      (mem_en),
        .mem_we      (mem_we),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata)
    );

    chr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (step_go && has_result) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_go && has_result) begin
            res_reg <= res;
        end
    end

    // ram read data is held until the next read, which waits for this result to leave
    assign m_valid          = out_vld_reg;
    assign m_status         = res_reg.status;
    assign m_msg_id         = res_reg.msg_id;
    assign m_message_length = res_reg.message_length;
    assign m_chunks_taken   = res_reg.chunks_taken;
    assign m_read_data      = res_reg.rd_sel ? mem_rdata : '0;

`ifndef SYNTHESIS
    a_no_loss_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_ready) |-> !(step_go && has_result))
        else $error("result overwritten while stalled");

    a_held_read_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_ready && res_reg.rd_sel) |=> $stable(m_read_data))
        else $error("read data changed while stalled");

    a_read_has_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && res_reg.rd_sel) |-> res_reg.status == STAT_READ)
        else $error("read select on a chunk result");
`endif

endmodule

@@ tb/sv/chunk_header_check_and_reassembly_chk.sv @@
// checker: watches both channels, predicts each result of the reassembly block and compares
`timescale 1ns / 1ps

module chunk_header_check_and_reassembly_chk
    import chr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic [LEN_W-1:0]    cfg_wr_data,

    input  logic                s_valid,
    input  logic                s_ready,
    input  logic                s_kind,
    input  logic [BYTE_W-1:0]   s_data_byte,
    input  logic                s_end_of_chunk,
    input  logic [RIDX_W-1:0]   s_read_index,

    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [STAT_W-1:0]   m_status,
    input  logic [ID_W-1:0]     m_msg_id,
    input  logic [LEN_W-1:0]    m_message_length,
    input  logic [CHUNK_W-1:0]  m_chunks_taken,
    input  logic [BYTE_W-1:0]   m_read_data,

    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        status_t              status;
        logic [ID_W-1:0]      msg_id;
        logic [LEN_W-1:0]     message_length;
        logic [CHUNK_W-1:0]   chunks_taken;
        logic [BYTE_W-1:0]    read_data;
    } outcome_t;

    outcome_t               awaited_q[$];
    int                     errors;

    logic [BYTE_W-1:0]      msg_store [CHR_STORE_BYTES];
    logic [LEN_W-1:0]       asm_len;
    logic [ID_W-1:0]        open_id;
    logic [CHUNK_W-1:0]     open_count;
    logic [CHUNK_W-1:0]     next_idx;
    int                     hdr_pos;
    logic [31:0]            hdr;
    verdict_t               verdict;
    logic [LEN_W-1:0]       msg_limit;

    initial begin
        fail_count = 0;
        pending = 0;
        errors = 0;
    end

    function automatic logic [LEN_W-1:0] eff_limit();
        return (msg_limit < LEN_W'(CHR_STORE_BYTES)) ? msg_limit : LEN_W'(CHR_STORE_BYTES);
    endfunction

    task automatic close_message();
        asm_len = '0;
        open_id = '0;
        open_count = '0;
        next_idx = '0;
    endtask

    task automatic reassemble_item(
        input  logic                kind,
        input  logic [BYTE_W-1:0]   b,
        input  logic                last,
        input  logic [RIDX_W-1:0]   ridx,
        output bit                  has,
        output outcome_t            r
    );
        logic [BYTE_W-1:0]  rd;
        logic [ID_W-1:0]    h_id;
        logic [CHUNK_W-1:0] h_idx;
        logic [CHUNK_W-1:0] h_cnt;
        status_t            st;
        has = 1'b0;
        r = '0;
        if (kind) begin
            rd = '0;
            if (LEN_W'(ridx) < asm_len) rd = msg_store[ridx];
            has = 1'b1;
            r = '{STAT_READ, open_id, asm_len, next_idx, rd};
        end else begin
            if (hdr_pos < CHR_HEADER_BYTES) begin
                hdr = {hdr[23:0], b};
                hdr_pos++;
                if (hdr_pos == CHR_HEADER_BYTES) begin
                    h_id = hdr[31:16];
                    h_idx = hdr[15:8];
                    h_cnt = hdr[7:0];
                    if (h_cnt == '0 || h_idx >= h_cnt) begin
                        verdict = VERDICT_BAD;
                    end else begin
                        if (h_idx == '0) begin
                            close_message();
                            open_id = h_id;
                            open_count = h_cnt;
                        end
                        if (open_count == '0 || open_id != h_id || open_count != h_cnt ||
                                next_idx != h_idx) begin
                            close_message();
                            verdict = VERDICT_SEQ;
                        end else if (asm_len > eff_limit()) begin
                            close_message();
                            verdict = VERDICT_OVF;
                        end else begin
                            verdict = VERDICT_GOOD;
                        end
                    end
                end
            end else if (verdict == VERDICT_GOOD) begin
                if (asm_len >= eff_limit()) begin
                    close_message();
                    verdict = VERDICT_OVF;
                end else begin
                    msg_store[asm_len] = b;
                    asm_len++;
                end
            end
            if (last) begin
                if (hdr_pos < CHR_HEADER_BYTES || verdict == VERDICT_BAD) begin
                    st = STAT_BAD_HEADER;
                end else if (verdict == VERDICT_SEQ) begin
                    st = STAT_SEQ_RESET;
                end else if (verdict == VERDICT_OVF) begin
                    st = STAT_OVF_RESET;
                end else begin
                    next_idx++;
                    if (next_idx == open_count) st = STAT_COMPLETE;
                    else st = STAT_ACCEPTED;
                end
                hdr_pos = 0;
                hdr = '0;
                verdict = VERDICT_GOOD;
                has = 1'b1;
                r = '{st, open_id, asm_len, next_idx, 8'h00};
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        outcome_t want;
        outcome_t fresh;
        bit       has;
        if (!aresetn) begin
            awaited_q.delete();
            close_message();
            hdr_pos = 0;
            hdr = '0;
            verdict = VERDICT_GOOD;
            msg_limit = LIMIT_RESET;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result item: status %0d id %h len %0d %s",
                                 $time, m_status, m_msg_id, m_message_length,
                                 $sformatf("chunks %0d data %h", m_chunks_taken, m_read_data));
                end else begin
                    want = awaited_q.pop_front();
                    if (m_status !== want.status || m_msg_id !== want.msg_id ||
                            m_message_length !== want.message_length ||
                            m_chunks_taken !== want.chunks_taken ||
                            m_read_data !== want.read_data) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: result item differs", $time);
                            $display("  expected status %0d id %h len %0d chunks %0d data %h",
                                     want.status, want.msg_id, want.message_length,
                                     want.chunks_taken, want.read_data);
                            $display("  got      status %0d id %h len %0d chunks %0d data %h",
                                     m_status, m_msg_id, m_message_length,
                                     m_chunks_taken, m_read_data);
                        end
                    end
                end
            end
            if (cfg_wr_en) msg_limit = cfg_wr_data;
            if (s_valid && s_ready) begin
                reassemble_item(s_kind, s_data_byte, s_end_of_chunk, s_read_index, has, fresh);
                if (has) awaited_q.push_back(fresh);
            end
        end
        pending <= awaited_q.size();
        fail_count <= errors;
    end

endmodule

@@ tb/sv/chunk_header_check_and_reassembly_tb.sv @@
// testbench top: clock, reset, stimulus phases and verdict for the chunk reassembly block
`timescale 1ns / 1ps

module chunk_header_check_and_reassembly_tb;
    import chr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 100;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {
        FLAW_ID,
        FLAW_COUNT,
        FLAW_INDEX,
        FLAW_SHORT,
        FLAW_ZERO_COUNT,
        FLAW_SKIP
    } flaw_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [LEN_W-1:0]    cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_kind = 1'b0;
    logic [BYTE_W-1:0]   s_data_byte = '0;
    logic                s_end_of_chunk = 1'b0;
    logic [RIDX_W-1:0]   s_read_index = '0;
    logic                m_valid;
    logic                m_ready;
    logic [STAT_W-1:0]   m_status;
    logic [ID_W-1:0]     m_msg_id;
    logic [LEN_W-1:0]    m_message_length;
    logic [CHUNK_W-1:0]  m_chunks_taken;
    logic [BYTE_W-1:0]   m_read_data;

    int fail_count;
    int pending;
    int cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int read_pct = 0;
    int items_sent = 0;
    int holds_asked = 0;

    chunk_header_check_and_reassembly i_dut (.*);

    chunk_header_check_and_reassembly_chk i_chk (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("chunk_header_check_and_reassembly: mismatch");
            $finish;
        end
    end

    initial begin : receiver
        int hold_left;
        int holds_seen;
        hold_left = 0;
        holds_seen = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_seen != holds_asked) begin
                holds_seen = holds_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic offer(input logic kind, input logic [BYTE_W-1:0] b, input logic last,
                         input logic [RIDX_W-1:0] ridx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_data_byte <= b;
        s_end_of_chunk <= last;
        s_read_index <= ridx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        offer(1'b0, b, last, RIDX_W'($urandom));
    endtask

    task automatic send_read(input logic [RIDX_W-1:0] ridx);
        offer(1'b1, BYTE_W'($urandom), 1'($urandom), ridx);
    endtask

    function automatic logic [RIDX_W-1:0] pick_read();
        if ($urandom_range(99) < 80) return RIDX_W'($urandom_range(47));
        return RIDX_W'($urandom_range(1023));
    endfunction

    function automatic int pick_payload();
        int r;
        r = $urandom_range(99);
        if (r < 85) return $urandom_range(8);
        if (r < 97) return $urandom_range(40, 9);
        return $urandom_range(250, 100);
    endfunction

    task automatic maybe_read();
        if ($urandom_range(99) < read_pct) send_read(pick_read());
    endtask

    task automatic send_chunk(input logic [ID_W-1:0] id, input logic [CHUNK_W-1:0] idx,
                              input logic [CHUNK_W-1:0] cnt, input int hdr_bytes,
                              input int payload);
        logic [31:0] hdr;
        hdr = {id, idx, cnt};
        for (int i = 0; i < hdr_bytes; i++) begin
            maybe_read();
            send_byte(hdr[31-8*i -: 8],
                      (i == hdr_bytes - 1) && (hdr_bytes < CHR_HEADER_BYTES || payload == 0));
        end
        if (hdr_bytes == CHR_HEADER_BYTES) begin
            for (int i = 0; i < payload; i++) begin
                maybe_read();
                send_byte(BYTE_W'($urandom), i == payload - 1);
            end
        end
    endtask

    task automatic send_message();
        logic [ID_W-1:0]    id;
        logic [ID_W-1:0]    send_id;
        logic [CHUNK_W-1:0] cnt;
        logic [CHUNK_W-1:0] send_cnt;
        logic [CHUNK_W-1:0] idx;
        int                 chunks;
        int                 hdr_bytes;
        int                 r;
        flaw_t              flaw;
        id = ID_W'($urandom);
        r = $urandom_range(99);
        if (r < 70) cnt = CHUNK_W'($urandom_range(4, 1));
        else if (r < 90) cnt = CHUNK_W'($urandom_range(12, 5));
        else cnt = CHUNK_W'($urandom_range(255, 1));
        if (cnt <= 6 && $urandom_range(9) != 0) chunks = cnt;
        else chunks = $urandom_range(6, 1);
        for (int c = 0; c < chunks; c++) begin
            send_id = id;
            send_cnt = cnt;
            idx = CHUNK_W'(c);
            hdr_bytes = CHR_HEADER_BYTES;
            if ($urandom_range(99) < 12) begin
                flaw = flaw_t'($urandom_range(FLAW_SKIP));
                case (flaw)
                    FLAW_ID:         send_id = id ^ ID_W'(1 << $urandom_range(15));
                    FLAW_COUNT:      send_cnt = cnt + CHUNK_W'($urandom_range(3, 1));
                    FLAW_INDEX:      idx = CHUNK_W'($urandom);
                    FLAW_SHORT:      hdr_bytes = $urandom_range(CHR_HEADER_BYTES - 1, 1);
                    FLAW_ZERO_COUNT: send_cnt = '0;
                    default:         idx = idx + 1'b1;
                endcase
            end
            send_chunk(send_id, idx, send_cnt, hdr_bytes, pick_payload());
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++)
            send_byte(BYTE_W'($urandom),
                      (i == n - 1) ? ($urandom_range(9) != 0) : 1'($urandom));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [LEN_W-1:0] v);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        logic [LEN_W-1:0] limits [6];
        int               idle_of [4];
        int               stall_of [4];
        int               start;
        int               r;
        limits = '{11'd2047, 11'd24, 11'd0, 11'd1024, 11'd100, 11'd1};
        idle_of = '{0, 82, 0, 11};
        stall_of = '{0, 0, 82, 11};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        set_limit(11'd2);
        send_read(10'd0);
        send_chunk(16'hABCD, 8'd0, 8'd0, 1, 0);
        send_chunk(16'h1234, 8'd0, 8'd0, 4, 0);
        send_chunk(16'hFFFF, 8'd2, 8'd2, 4, 0);
        send_chunk(16'hFFFF, 8'd0, 8'd2, 4, 2);
        send_read(10'd1);
        send_read(10'd2);
        send_chunk(16'hFFFF, 8'd1, 8'd2, 4, 1);
        send_chunk(16'h0001, 8'd1, 8'd2, 4, 0);
        send_chunk(16'h00FF, 8'd0, 8'd1, 4, 0);

        for (int p = 0; p < 6; p++) begin
            set_limit(limits[p]);
            send_idle_pct = idle_of[p % 4];
            stall_pct = stall_of[p % 4];
            read_pct = 15;
            if (p == 4) holds_asked++;
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 75) send_message();
                else if (r < 90) send_read(pick_read());
                else send_noise();
            end
        end

        drain_results();
        if (fail_count == 0 && pending == 0) begin
            $display("chunk_header_check_and_reassembly: match");
        end else begin
            $display("chunk_header_check_and_reassembly: mismatch");
        end
        $finish;
    end

endmodule
